[hdl/interval_overwrite_table_unit_macros.svh]
// Assertion macros for the interval overwrite table unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef INTERVAL_OVERWRITE_TABLE_UNIT_MACROS_SVH
`define INTERVAL_OVERWRITE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IOTU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iotu assertion failed");

// Next-cycle implication, checked out of reset.
`define IOTU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iotu assertion failed");

`endif

[hdl/iotu_pkg.sv]
// Package for the interval overwrite table unit: sizes, codes and item types.
// No dependencies.
`timescale 1ns / 1ps
package iotu_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TMP_W = $clog2(MAX_ENTRIES + 3);

  typedef enum logic [2:0] {
    KIND_REMOVED     = 3'd0,
    KIND_TRIMMED     = 3'd1,
    KIND_SPLIT_RIGHT = 3'd2,
    KIND_INSERTED    = 3'd3,
    KIND_REJ_EMPTY   = 3'd4,
    KIND_REJ_FULL    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] src;
  } entry_t;

  typedef struct packed {
    logic [15:0] new_id;
    logic [31:0] new_start;
    logic [31:0] new_duration;
    logic [31:0] new_source_start;
  } in_item_t;

  typedef struct packed {
    kind_e       report_kind;
    logic [15:0] clip_id;
    logic [31:0] clip_start;
    logic [31:0] clip_duration;
    logic [31:0] clip_source_start;
    logic [4:0]  entry_total;
    logic        last_report;
  } out_item_t;

  // Outcome of classifying the head entry against the new span.
  typedef struct packed {
    logic   removed;
    logic   split;
    logic   has_keep;
    entry_t keep;
    logic   has_rep;
    kind_e  rep_kind;
    entry_t rep;
    logic   done;
  } cls_t;

endpackage

[hdl/iotu_cell.sv]
// One table cell of the interval overwrite table chain.
// Depends on iotu_pkg.
`timescale 1ns / 1ps
module iotu_cell import iotu_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             shift_i,
  input  entry_t           next_i,
  input  logic             load_i,
  input  logic [IDX_W-1:0] load_pos_i,
  input  entry_t           load_entry_i,
  output entry_t           entry_o
);

  entry_t entry_q, entry_d;

  // A load aimed at this cell wins over the shift from the neighbour.
  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = next_i;
    end
    if (load_i && (load_pos_i == idx_i)) begin
      entry_d = load_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hdl/iotu_classify.sv]
// Classifies the head table entry against the new span and forms the
// surviving piece and its report. Depends on iotu_pkg.
`timescale 1ns / 1ps
module iotu_classify import iotu_pkg::*; (
  input  entry_t e_i,
  input  entry_t nw_i,
  input  logic   half_i,
  output cls_t   cls_o
);

  logic [32:0] ee;
  logic [31:0] ne;
  logic        outside, covered, contains;
  entry_t      left_part, right_part;

  always_comb begin
    ee = {1'b0, e_i.start} + {1'b0, e_i.len};
    // The span end fits in 32 bits because the duration was saturated.
    ne = nw_i.start + nw_i.len;
    outside  = (ee <= {1'b0, nw_i.start}) || (e_i.start >= ne);
    covered  = (nw_i.start <= e_i.start) && ({1'b0, ne} >= ee);
    contains = (e_i.start < nw_i.start) && (ee > {1'b0, ne});

    left_part  = '{id: e_i.id, start: e_i.start, len: nw_i.start - e_i.start,
                   src: e_i.src};
    right_part = '{id: e_i.id, start: ne, len: ee[31:0] - ne,
                   src: e_i.src + (ne - e_i.start)};

    cls_o          = '0;
    cls_o.removed  = !outside && covered;
    cls_o.split    = !outside && !covered && contains;
    cls_o.rep_kind = KIND_TRIMMED;
    cls_o.done     = 1'b1;
    if (outside) begin
      cls_o.has_keep = 1'b1;
      cls_o.keep     = e_i;
    end else if (covered) begin
      cls_o.has_rep  = 1'b1;
      cls_o.rep_kind = KIND_REMOVED;
      cls_o.rep      = e_i;
    end else if (contains) begin
      // Left part on the first half, right part on the second.
      cls_o.has_keep = 1'b1;
      cls_o.has_rep  = 1'b1;
      cls_o.keep     = half_i ? right_part : left_part;
      cls_o.rep      = cls_o.keep;
      cls_o.rep_kind = half_i ? KIND_SPLIT_RIGHT : KIND_TRIMMED;
      cls_o.done     = half_i;
    end else if (e_i.start >= nw_i.start) begin
      cls_o.has_keep = 1'b1;
      cls_o.has_rep  = 1'b1;
      cls_o.keep     = right_part;
      cls_o.rep      = right_part;
    end else begin
      cls_o.has_keep = 1'b1;
      cls_o.has_rep  = 1'b1;
      cls_o.keep     = left_part;
      cls_o.rep      = left_part;
    end
  end

endmodule

[hdl/interval_overwrite_table_unit.sv]
// Top level of the interval overwrite table unit: cell chain and sequencer.
// Depends on iotu_pkg, iotu_cell, iotu_classify and the macros header.
//
//   channel | signals                          | carries
//   in      | in_valid_i, in_ready_o, in_item_i    | one insert item
//   out     | out_valid_o, out_ready_i, out_item_o | one report per transfer
//
// An insert goes from idle to check, then, if the table holds entries, through a
// counting pass that rotates the chain to size the edited table, then to decide and
// an editing pass that handles each head entry once (twice for a split), places the
// new interval and closes, then to the final report and back to idle. A rejected
// empty insert goes from check back to idle, a rejected full one from decide.
// Reset empties the table at once; no clearing pass is needed.
// A report waiting in the output register stalls the editing and final steps, and
// the check and decide steps when they reject; one item is in work at a time.
`timescale 1ns / 1ps
`include "interval_overwrite_table_unit_macros.svh"
module interval_overwrite_table_unit import iotu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_COUNT  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EDIT   = 3'd4;
  localparam logic [2:0] ST_FINAL  = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [TMP_W-1:0] wcnt_q, wcnt_d;
  logic [TMP_W-1:0] total_q, total_d;
  logic             placed_q, placed_d;
  logic             half_q, half_d;
  entry_t           nw_q, nw_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  entry_t           cells [MAX_ENTRIES];
  logic             shift, load;
  logic [IDX_W-1:0] load_pos;
  entry_t           load_entry;
  cls_t             cls;
  logic             out_free, emit;
  out_item_t        emit_item;
  logic [TMP_W:0]   pos_wide;
  logic [31:0]      dur_sat;

  // Cell chain: each cell takes its upper neighbour when the head pops.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t nxt;
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign nxt = cells[g];
    end else begin : g_mid
      assign nxt = cells[g+1];
    end
    iotu_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(g)),
      .shift_i     (shift),
      .next_i      (nxt),
      .load_i      (load),
      .load_pos_i  (load_pos),
      .load_entry_i(load_entry),
      .entry_o     (cells[g])
    );
  end

  iotu_classify u_classify (
    .e_i   (cells[0]),
    .nw_i  (nw_q),
    .half_i(half_q),
    .cls_o (cls)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Saturate the duration so that the end stays inside the time range.
  assign dur_sat = (in_item_i.new_duration > ~in_item_i.new_start) ?
                   ~in_item_i.new_start : in_item_i.new_duration;

  // Sequencer.
  always_comb begin
    st_d       = st_q;
    count_d    = count_q;
    rem_d      = rem_q;
    wcnt_d     = wcnt_q;
    total_d    = total_q;
    placed_d   = placed_q;
    half_d     = half_q;
    nw_d       = nw_q;
    shift      = 1'b0;
    load       = 1'b0;
    load_entry = cls.keep;
    pos_wide   = '0;
    emit       = 1'b0;
    emit_item  = '{report_kind: KIND_INSERTED, clip_id: nw_q.id,
                   clip_start: nw_q.start, clip_duration: nw_q.len,
                   clip_source_start: nw_q.src, entry_total: 5'(count_q),
                   last_report: 1'b1};

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          nw_d = '{id: in_item_i.new_id, start: in_item_i.new_start,
                   len: dur_sat, src: in_item_i.new_source_start};
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (nw_q.len == '0) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item.report_kind = KIND_REJ_EMPTY;
            st_d = ST_IDLE;
          end
        end else begin
          rem_d   = count_q;
          total_d = TMP_W'(count_q) + TMP_W'(1);
          st_d    = (count_q == '0) ? ST_DECIDE : ST_COUNT;
        end
      end
      ST_COUNT: begin
        // Rotate the head to the tail while counting the edited size.
        shift      = 1'b1;
        load       = 1'b1;
        load_entry = cells[0];
        pos_wide   = (TMP_W+1)'(count_q) - (TMP_W+1)'(1);
        if (cls.split) begin
          total_d = total_q + TMP_W'(1);
        end else if (cls.removed) begin
          total_d = total_q - TMP_W'(1);
        end
        rem_d = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1)) begin
          st_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (total_q > TMP_W'(MAX_ENTRIES)) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item.report_kind = KIND_REJ_FULL;
            st_d = ST_IDLE;
          end
        end else begin
          rem_d    = count_q;
          wcnt_d   = '0;
          placed_d = 1'b0;
          half_d   = 1'b0;
          st_d     = ST_EDIT;
        end
      end
      ST_EDIT: begin
        if (out_free) begin
          if (rem_q == '0) begin
            if (!placed_q) begin
              load       = 1'b1;
              load_entry = nw_q;
              pos_wide   = (TMP_W+1)'(wcnt_q);
              wcnt_d     = wcnt_q + TMP_W'(1);
              placed_d   = 1'b1;
            end else begin
              st_d = ST_FINAL;
            end
          end else if (cls.has_keep && !placed_q && (cls.keep.start > nw_q.start)) begin
            // The new interval goes in ahead of the first later piece.
            load       = 1'b1;
            load_entry = nw_q;
            pos_wide   = (TMP_W+1)'(rem_q) + (TMP_W+1)'(wcnt_q);
            wcnt_d     = wcnt_q + TMP_W'(1);
            placed_d   = 1'b1;
          end else begin
            shift    = cls.done;
            load     = cls.has_keep;
            pos_wide = (TMP_W+1)'(rem_q) + (TMP_W+1)'(wcnt_q) -
                       (TMP_W+1)'(cls.done);
            if (cls.has_keep) begin
              wcnt_d = wcnt_q + TMP_W'(1);
            end
            if (cls.has_rep) begin
              emit = 1'b1;
              emit_item = '{report_kind: cls.rep_kind, clip_id: cls.rep.id,
                            clip_start: cls.rep.start, clip_duration: cls.rep.len,
                            clip_source_start: cls.rep.src,
                            entry_total: 5'(total_q), last_report: 1'b0};
            end
            if (cls.done) begin
              rem_d  = rem_q - CNT_W'(1);
              half_d = 1'b0;
            end else begin
              half_d = 1'b1;
            end
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.entry_total = 5'(wcnt_q);
          count_d = CNT_W'(wcnt_q);
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    load_pos = pos_wide[IDX_W-1:0];
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      wcnt_q      <= '0;
      total_q     <= '0;
      placed_q    <= 1'b0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      wcnt_q      <= wcnt_d;
      total_q     <= total_d;
      placed_q    <= placed_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nw_q  <= nw_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The stored count never passes the table size.
  `IOTU_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(MAX_ENTRIES))
  // While editing, unprocessed and written entries fit in the chain.
  `IOTU_ASSERT_IMP(a_edit_fits, st_q == ST_EDIT,
                   (TMP_W+1)'(rem_q) + (TMP_W+1)'(wcnt_q) <= (TMP_W+1)'(MAX_ENTRIES))
  // The final report commits the written size as the new count.
  `IOTU_ASSERT_NXT(a_final_commit, st_q == ST_FINAL && out_free,
                   count_q == CNT_W'($past(wcnt_q)) && st_q == ST_IDLE)

endmodule

[dv/interval_overwrite_table_unit_tb.sv]
// Testbench for the interval overwrite table unit: random and directed inserts,
// checked against a behavioural table kept in the bench. Depends on iotu_pkg.
`timescale 1ns / 1ps
module interval_overwrite_table_unit_tb;
  import iotu_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  interval_overwrite_table_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the interval table.
  entry_t    table_q [$];
  out_item_t report_q [$];
  in_item_t  insert_q [$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;
  bit        in_taken = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  task automatic add_report(input out_item_t r);
    report_q.insert(report_q.size(), r);
  endtask

  task automatic add_insert(input in_item_t it);
    insert_q.insert(insert_q.size(), it);
  endtask

  function automatic out_item_t mk_report(kind_e k, entry_t e, int total, bit last);
    out_item_t r;
    r.report_kind = k;
    r.clip_id = e.id;
    r.clip_start = e.start;
    r.clip_duration = e.len;
    r.clip_source_start = e.src;
    r.entry_total = total[4:0];
    r.last_report = last;
    return r;
  endfunction

  // Work out the reports of one insert and update the shadow table.
  task automatic predict_overwrite(input in_item_t it);
    entry_t      nw, e, edited [$];
    out_item_t   reps [$];
    logic [32:0] ne, ee;
    bit          placed;
    nw.id = it.new_id;
    nw.start = it.new_start;
    nw.len = it.new_duration;
    nw.src = it.new_source_start;
    placed = 1'b0;
    if (nw.len > 32'hFFFF_FFFF - nw.start) nw.len = 32'hFFFF_FFFF - nw.start;
    if (nw.len == 0) begin
      add_report(mk_report(KIND_REJ_EMPTY, nw, table_q.size(), 1'b1));
      return;
    end
    ne = {1'b0, nw.start} + nw.len;
    foreach (table_q[i]) begin
      entry_t a, b;
      e = table_q[i];
      ee = {1'b0, e.start} + e.len;
      if (ee <= nw.start || e.start >= ne) begin
        a = e;
      end else if (nw.start <= e.start && ne >= ee) begin
        reps = {reps, mk_report(KIND_REMOVED, e, 0, 1'b0)};
        continue;
      end else if (e.start < nw.start && ee > ne) begin
        a = e;
        a.len = nw.start - e.start;
        b = e;
        b.start = ne[31:0];
        b.len = 32'(ee - ne);
        b.src = e.src + 32'(ne - e.start);
        reps = {reps, mk_report(KIND_TRIMMED, a, 0, 1'b0)};
        reps = {reps, mk_report(KIND_SPLIT_RIGHT, b, 0, 1'b0)};
        edited = {edited, a};
        if (!placed) begin
          edited = {edited, nw};
          placed = 1'b1;
        end
        a = b;
      end else if (e.start >= nw.start) begin
        a = e;
        a.start = ne[31:0];
        a.len = 32'(ee - ne);
        a.src = e.src + 32'(ne - e.start);
        reps = {reps, mk_report(KIND_TRIMMED, a, 0, 1'b0)};
      end else begin
        a = e;
        a.len = nw.start - e.start;
        reps = {reps, mk_report(KIND_TRIMMED, a, 0, 1'b0)};
      end
      // The new interval goes in front of the first kept entry past its start.
      if (!placed && a.start > nw.start) begin
        edited = {edited, nw};
        placed = 1'b1;
      end
      edited = {edited, a};
    end
    if (!placed) edited = {edited, nw};
    if (edited.size() > MAX_ENTRIES) begin
      add_report(mk_report(KIND_REJ_FULL, nw, table_q.size(), 1'b1));
      return;
    end
    table_q = edited;
    foreach (reps[i]) begin
      reps[i].entry_total = 5'(edited.size());
      add_report(reps[i]);
    end
    add_report(mk_report(KIND_INSERTED, nw, edited.size(), 1'b1));
  endtask

  function automatic in_item_t mk_insert(logic [15:0] id, logic [31:0] st,
                                         logic [31:0] du, logic [31:0] sr);
    in_item_t it;
    it.new_id = id;
    it.new_start = st;
    it.new_duration = du;
    it.new_source_start = sr;
    return it;
  endfunction

  // Mostly small times in a narrow window so that inserts overlap often.
  function automatic in_item_t rand_insert();
    logic [31:0] st, du;
    int sel;
    sel = $urandom_range(0, 19);
    st = $urandom_range(0, 4000);
    du = $urandom_range(1, 600);
    if (sel == 0) du = 0;
    else if (sel == 1) begin
      st = $urandom;
      du = $urandom;
    end else if (sel == 2) st = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else if (sel == 3) du = $urandom_range(1, 20);
    return mk_insert(16'($urandom), st, du, $urandom);
  endfunction

  // Driver: offers queued inserts with random gaps, changes at the falling edge.
  // An offered insert is held until the rising edge that takes it.
  int drv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid_i <= 1'b0;
        end else if (insert_q.size() > 0) begin
          in_item_i <= insert_q.pop_front();
          in_valid_i <= 1'b1;
          drv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                   : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Prediction runs at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1'b1;
      predict_overwrite(in_item_i);
    end
  end

  // Receiver back-pressure; a requested long hold is counted here.
  int rx_gap = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_gap <= 300;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 7) == 0)
        rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                : $urandom_range(1, 3);
    end
  end

  // Monitor: checks every report transfer against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) report_mismatch("report with none expected");
      else begin
        exp_r = report_q.pop_front();
        if (out_item_o.report_kind !== exp_r.report_kind) report_mismatch("report_kind");
        if (out_item_o.clip_id !== exp_r.clip_id) report_mismatch("clip_id");
        if (out_item_o.clip_start !== exp_r.clip_start) report_mismatch("clip_start");
        if (out_item_o.clip_duration !== exp_r.clip_duration)
          report_mismatch("clip_duration");
        if (out_item_o.clip_source_start !== exp_r.clip_source_start)
          report_mismatch("clip_source_start");
        if (out_item_o.entry_total !== exp_r.entry_total) report_mismatch("entry_total");
        if (out_item_o.last_report !== exp_r.last_report) report_mismatch("last_report");
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (insert_q.size() > 0 || in_valid_i || report_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int k;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, empty, saturation, trims, split, removal, full table.
    add_insert(mk_insert(16'h0000, 32'd0, 32'd0, 32'd0));
    add_insert(mk_insert(16'hFFFF, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF));
    add_insert(mk_insert(16'h0001, 32'd100, 32'd100, 32'hFFFF_FFF0));
    add_insert(mk_insert(16'h0002, 32'd150, 32'd10, 32'd7));
    add_insert(mk_insert(16'h0003, 32'd90, 32'd20, 32'd1));
    add_insert(mk_insert(16'h0004, 32'd190, 32'd50, 32'd2));
    add_insert(mk_insert(16'h0005, 32'd0, 32'd1000, 32'd3));
    add_insert(mk_insert(16'h0006, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hAAAA_5555));
    add_insert(mk_insert(16'h0007, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA));
    for (k = 0; k < 16; k++)
      add_insert(mk_insert(16'(16 + k), 32'(5000 + 10 * k), 32'd5, 32'(k)));
    add_insert(mk_insert(16'h0030, 32'd5002, 32'd1, 32'd9));
    wait_drained();
    // Long receiver hold while the sender keeps offering.
    hold_req = 1'b1;
    for (k = 0; k < 6; k++) add_insert(rand_insert());
    wait_drained();
    for (k = 0; k < 180; k++) begin
      add_insert(rand_insert());
      if (k == 90) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && report_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[interval_overwrite_table_unit.f]
+incdir+hdl
hdl/iotu_pkg.sv
hdl/iotu_cell.sv
hdl/iotu_classify.sv
hdl/interval_overwrite_table_unit.sv
dv/interval_overwrite_table_unit_tb.sv
